// ===== rtl/chfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chfp_pkg
// Shared types and constants of the color histogram foreground probability block.
// ----------------------------------------------------------------------------
package chfp_pkg;

	localparam int MAX_BINS    = 16;
	localparam int COUNT_WIDTH = 20;
	localparam int BIN_W       = $clog2(MAX_BINS);
	localparam int IDX_W       = 3 * BIN_W;
	localparam int HIST_DEPTH  = MAX_BINS * MAX_BINS * MAX_BINS;
	localparam int PROB_W      = 16;
	localparam int STEP_W      = $clog2(PROB_W);
	localparam int DEN_W       = COUNT_WIDTH + 2;
	localparam int NUM_W       = COUNT_WIDTH + 1 + PROB_W;
	localparam int REM_W       = NUM_W + 1;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	// smallest shift whose bin count fits MAX_BINS
	localparam logic [2:0] MIN_SHIFT = 3'(8 - BIN_W);

	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_ACC   = 2'd1;
	localparam logic [1:0] MODE_LOOK  = 2'd2;

	localparam logic [2:0] REG_BIN_SHIFT  = 3'd0;
	localparam logic [2:0] REG_OBJ_LEFT   = 3'd1;
	localparam logic [2:0] REG_OBJ_TOP    = 3'd2;
	localparam logic [2:0] REG_OBJ_RIGHT  = 3'd3;
	localparam logic [2:0] REG_OBJ_BOTTOM = 3'd4;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_ACC,
		OP_LOOK
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
		logic             in_obj;
	} req_t;

endpackage
`default_nettype wire

// ===== rtl/chfp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chfp_front
// Holds configuration, bins each request and tests it against the object rectangle.
// ----------------------------------------------------------------------------
module chfp_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [9:0]         cfg_data,
	input  wire logic               accept,
	input  wire logic [1:0]         mode,
	input  wire logic [7:0]         chan_a,
	input  wire logic [7:0]         chan_b,
	input  wire logic [7:0]         chan_c,
	input  wire logic [9:0]         col,
	input  wire logic [9:0]         row,
	output logic                    req_push,
	output chfp_pkg::req_t          req
);
	import chfp_pkg::*;

	logic [2:0] bin_shift_q;
	logic [9:0] obj_left_q, obj_top_q, obj_right_q, obj_bottom_q;
	logic [2:0] shift;
	logic [3:0] bits;
	logic [BIN_W-1:0] bin_a, bin_b, bin_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_shift_q  <= 3'd4;
			obj_left_q   <= '0;
			obj_top_q    <= '0;
			obj_right_q  <= '0;
			obj_bottom_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BIN_SHIFT:  bin_shift_q  <= cfg_data[2:0];
				REG_OBJ_LEFT:   obj_left_q   <= cfg_data;
				REG_OBJ_TOP:    obj_top_q    <= cfg_data;
				REG_OBJ_RIGHT:  obj_right_q  <= cfg_data;
				REG_OBJ_BOTTOM: obj_bottom_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		shift = (bin_shift_q > MIN_SHIFT) ? bin_shift_q : MIN_SHIFT;
		bits  = 4'd8 - {1'b0, shift};
		bin_a = BIN_W'(chan_a >> shift);
		bin_b = BIN_W'(chan_b >> shift);
		bin_c = BIN_W'(chan_c >> shift);
		req.idx = (IDX_W'(bin_a) << (2 * bits)) | (IDX_W'(bin_b) << bits) | IDX_W'(bin_c);
		req.in_obj = (col >= obj_left_q) && (col <= obj_right_q) &&
			(row >= obj_top_q) && (row <= obj_bottom_q);
		req_push = accept;
		unique case (mode)
			MODE_CLEAR: req.op = OP_CLEAR;
			MODE_ACC:   req.op = OP_ACC;
			MODE_LOOK:  req.op = OP_LOOK;
			default: begin
				req.op   = OP_CLEAR;
				req_push = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/chfp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chfp_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module chfp_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire chfp_pkg::req_t din,
	input  wire logic           pop,
	output chfp_pkg::req_t      dout,
	output logic                empty,
	output logic                full
);
	import chfp_pkg::*;

	req_t             slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push, do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == (QPTR_W+1)'(QDEPTH));
	assign dout    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/chfp_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chfp_div
// Bit-serial rounded divider: (obj+1)/(surr+2) in Q0.16, saturated.
// ----------------------------------------------------------------------------
module chfp_div (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [chfp_pkg::COUNT_WIDTH-1:0] obj,
	input  wire logic [chfp_pkg::COUNT_WIDTH-1:0] surr,
	output logic                                  done,
	output logic [chfp_pkg::PROB_W-1:0]           quo
);
	import chfp_pkg::*;

	logic [REM_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [STEP_W-1:0] step_q;
	logic [PROB_W-1:0] quo_q;
	logic              busy_q, done_q;
	logic [NUM_W-1:0]  num;
	logic [DEN_W-1:0]  den;
	logic [REM_W-1:0]  n, den_full, den_sh;

	always_comb begin
		num      = {(COUNT_WIDTH+1)'(obj) + 1'b1, {PROB_W{1'b0}}};
		den      = DEN_W'(surr) + DEN_W'(2);
		n        = REM_W'(num) + REM_W'(den >> 1);
		den_full = REM_W'(den) << PROB_W;
		den_sh   = REM_W'(den_q) << step_q;
	end

	assign done = done_q;
	assign quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rem_q  <= '0;
			den_q  <= '0;
			step_q <= '0;
			quo_q  <= '0;
		end else if (start) begin
			if (n >= den_full) begin
				quo_q  <= {PROB_W{1'b1}};
				done_q <= 1'b1;
				busy_q <= 1'b0;
			end else begin
				rem_q  <= n;
				den_q  <= den;
				step_q <= STEP_W'(PROB_W - 1);
				quo_q  <= '0;
				done_q <= 1'b0;
				busy_q <= 1'b1;
			end
		end else if (busy_q) begin
			if (rem_q >= den_sh) begin
				rem_q         <= rem_q - den_sh;
				quo_q[step_q] <= 1'b1;
			end
			if (step_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/chfp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chfp_back
// Histogram memories, clear sweep, accumulate and lookup sequencer, result register.
// ----------------------------------------------------------------------------
module chfp_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_empty,
	input  wire chfp_pkg::req_t              q_head,
	output logic                             q_pop,
	output logic                             init_busy,
	input  wire logic                        pop,
	output logic                             empty,
	output logic [chfp_pkg::PROB_W-1:0]      probability,
	output logic [chfp_pkg::IDX_W-1:0]       bin_index
);
	import chfp_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RMW,
		ST_DIV
	} state_t;

	state_t             state_q;
	logic               init_q;
	req_t               cur_q;
	logic [IDX_W-1:0]   clr_addr_q;
	logic               out_valid_q;
	logic [PROB_W-1:0]  out_prob_q;
	logic [IDX_W-1:0]   out_idx_q;

	logic [COUNT_WIDTH-1:0] surr_mem [HIST_DEPTH];
	logic [COUNT_WIDTH-1:0] obj_mem  [HIST_DEPTH];
	logic [COUNT_WIDTH-1:0] surr_rd_s1, obj_rd_s1;

	logic                   surr_we, obj_we, div_start, div_done;
	logic [IDX_W-1:0]       wr_addr;
	logic [COUNT_WIDTH-1:0] surr_wd, obj_wd;
	logic [PROB_W-1:0]      div_quo;

	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign init_busy = init_q;
	assign empty     = !out_valid_q;
	assign probability = out_prob_q;
	assign bin_index   = out_idx_q;

	always_comb begin
		wr_addr   = (state_q == ST_CLEAR) ? clr_addr_q : cur_q.idx;
		surr_we   = (state_q == ST_CLEAR) || (state_q == ST_RMW && cur_q.op == OP_ACC);
		obj_we    = (state_q == ST_CLEAR) ||
			(state_q == ST_RMW && cur_q.op == OP_ACC && cur_q.in_obj);
		div_start = (state_q == ST_RMW) && (cur_q.op == OP_LOOK);
		if (state_q == ST_CLEAR) begin
			surr_wd = '0;
			obj_wd  = '0;
		end else begin
			surr_wd = (surr_rd_s1 == COUNT_MAX) ? surr_rd_s1 : surr_rd_s1 + 1'b1;
			obj_wd  = (obj_rd_s1 == COUNT_MAX) ? obj_rd_s1 : obj_rd_s1 + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (surr_we) surr_mem[wr_addr] <= surr_wd;
		if (q_pop)   surr_rd_s1 <= surr_mem[q_head.idx];
	end

	always_ff @(posedge clk) begin
		if (obj_we) obj_mem[wr_addr] <= obj_wd;
		if (q_pop)  obj_rd_s1 <= obj_mem[q_head.idx];
	end

	chfp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.obj    (obj_rd_s1),
		.surr   (surr_rd_s1),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			init_q      <= 1'b1;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
			cur_q       <= '0;
			out_prob_q  <= '0;
			out_idx_q   <= '0;
		end else begin
			if (pop && out_valid_q) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == IDX_W'(HIST_DEPTH - 1)) begin
						state_q <= ST_IDLE;
						init_q  <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (!q_empty) begin
						cur_q <= q_head;
						if (q_head.op == OP_CLEAR) begin
							clr_addr_q <= '0;
							state_q    <= ST_CLEAR;
						end else begin
							state_q <= ST_RMW;
						end
					end
				end
				ST_RMW: begin
					state_q <= (cur_q.op == OP_LOOK) ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					if (div_done && !out_valid_q) begin
						out_prob_q  <= div_quo;
						out_idx_q   <= cur_q.idx;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/color_histogram_foreground_prob.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// color_histogram_foreground_prob
// Joint color histograms of window and object, per-pixel foreground probability.
// ----------------------------------------------------------------------------
// Requests enter a four-entry queue; the back end drains it one at a time.
// Accumulate reads the histogram memories, then writes them back with a
// saturating increment. Look up reads the memories, then runs the
// bit-serial divider (one quotient bit per cycle, 16 bits); the result
// waits in an output register until popped. Clear sweeps all 4096 bins,
// one per cycle. After reset the same clearing pass runs with full held
// high; configuration writes are taken throughout.
module color_histogram_foreground_prob (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [2:0]                  cfg_index,
	input  wire logic [9:0]                  cfg_data,
	input  wire logic                        push,
	output logic                             full,
	input  wire logic [1:0]                  mode,
	input  wire logic [7:0]                  chan_a,
	input  wire logic [7:0]                  chan_b,
	input  wire logic [7:0]                  chan_c,
	input  wire logic [9:0]                  col,
	input  wire logic [9:0]                  row,
	output logic                             empty,
	input  wire logic                        pop,
	output logic [chfp_pkg::PROB_W-1:0]      probability,
	output logic [chfp_pkg::IDX_W-1:0]       bin_index
);
	import chfp_pkg::*;

	req_t req, q_head;
	logic req_push, q_full, q_empty, q_pop, init_busy, accept;

	assign full   = q_full || init_busy;
	assign accept = push && !full;

	chfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.mode      (mode),
		.chan_a    (chan_a),
		.chan_b    (chan_b),
		.chan_c    (chan_c),
		.col       (col),
		.row       (row),
		.req_push  (req_push),
		.req       (req)
	);

	chfp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (req_push),
		.din    (req),
		.pop    (q_pop),
		.dout   (q_head),
		.empty  (q_empty),
		.full   (q_full)
	);

	chfp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.init_busy   (init_busy),
		.pop         (pop),
		.empty       (empty),
		.probability (probability),
		.bin_index   (bin_index)
	);

	a_init_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> full && q_empty)
		else $error("request queue used during clearing pass");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty) |=> empty)
		else $error("result register reloaded on pop");

	a_no_result_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> empty)
		else $error("result during clearing pass");

endmodule
`default_nettype wire
